// ----- rtl/core/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types, constants and helpers for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int WORD_W  = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CAP_W-1:0]  cap_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

  typedef enum logic {
    RANK_TOUCH,
    RANK_FILL
  } rank_op_t;

  // key/data store write request
  typedef struct packed {
    logic  en;
    idx_t  idx;
    word_t key;
    word_t data;
  } slot_wr_t;

  // recency update request
  typedef struct packed {
    logic     en;
    rank_op_t op;
    idx_t     slot;
    idx_t     old_rank;
    count_t   used;
  } rank_cmd_t;

  // zero acts as one, anything above the slot count saturates
  function automatic count_t eff_capacity(input cap_t cap);
    int c;
    c = int'(cap);
    if (c == 0) c = 1;
    if (c > ENTRIES) c = ENTRIES;
    return count_t'(c);
  endfunction

endpackage

// ----- rtl/core/lkv_slot_mem.sv -----
// ----------------------------------------------------------------------------
// lkv_slot_mem
// Key and data storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lkv_slot_mem import lkv_pkg::*; (
  input  logic     clk,
  input  slot_wr_t wr,
  input  idx_t     rd_idx,
  output word_t    rd_key,
  output word_t    rd_data
);

  word_t key_mem  [ENTRIES];
  word_t data_mem [ENTRIES];
  word_t rd_key_r;
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.idx]  <= wr.key;
      data_mem[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r  <= key_mem[rd_idx];
    rd_data_r <= data_mem[rd_idx];
  end

  assign rd_key  = rd_key_r;
  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/lkv_rank_table.sv -----
// ----------------------------------------------------------------------------
// lkv_rank_table
// Per-slot recency ranks (0 = most recent) with touch and fill updates.
// ----------------------------------------------------------------------------
module lkv_rank_table import lkv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  rank_cmd_t cmd,
  input  idx_t      rd_idx,
  output idx_t      rd_rank
);

  idx_t ranks_r   [ENTRIES];
  idx_t ranks_nxt [ENTRIES];
  idx_t rd_rank_r;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ranks_nxt[i] = ranks_r[i];
      if (cmd.en) begin
        if (idx_t'(i) == cmd.slot) begin
          ranks_nxt[i] = '0;
        end else if (count_t'(i) < cmd.used) begin
          case (cmd.op)
            RANK_TOUCH: begin
              if (ranks_r[i] < cmd.old_rank) ranks_nxt[i] = ranks_r[i] + idx_t'(1);
            end
            RANK_FILL: begin
              ranks_nxt[i] = ranks_r[i] + idx_t'(1);
            end
            default: begin
              ranks_nxt[i] = ranks_r[i];
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) ranks_r[i] <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) ranks_r[i] <= ranks_nxt[i];
    end
  end

  // registered to line up with the key/data read
  always_ff @(posedge clk) begin
    rd_rank_r <= ranks_r[rd_idx];
  end

  assign rd_rank = rd_rank_r;

endmodule

// ----- rtl/core/lkv_seq.sv -----
// ----------------------------------------------------------------------------
// lkv_seq
// Sequencer: scans valid slots one a cycle through a shared compare stage,
// then applies the hit, fill or replace update and issues the result.
// ----------------------------------------------------------------------------
module lkv_seq import lkv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      in_action,
  input  word_t     in_key,
  input  word_t     in_value,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic      out_found,
  output word_t     out_read_data,
  input  count_t    eff_cap,
  output idx_t      rd_idx,
  input  word_t     rd_key,
  input  word_t     rd_data,
  input  idx_t      rd_rank,
  output slot_wr_t  slot_wr,
  output rank_cmd_t rank_cmd
);

  state_t state_r, state_nxt;

  logic   put_r,      put_nxt;
  word_t  key_r,      key_nxt;
  word_t  val_r,      val_nxt;
  count_t idx_r,      idx_nxt;
  logic   cmp_vld_r,  cmp_vld_nxt;
  idx_t   cmp_idx_r,  cmp_idx_nxt;
  logic   hit_r,      hit_nxt;
  idx_t   hit_idx_r,  hit_idx_nxt;
  idx_t   hit_rank_r, hit_rank_nxt;
  word_t  hit_data_r, hit_data_nxt;
  idx_t   victim_r,   victim_nxt;
  count_t used_r,     used_nxt;
  logic   out_vld_r,  out_vld_nxt;
  logic   found_r,    found_nxt;
  word_t  rdata_r,    rdata_nxt;

  logic   accept;
  logic   scan_issue;
  logic   upd_fire;
  logic   fill;
  idx_t   upd_idx;
  idx_t   lru_rank;

  assign fill     = !hit_r && (used_r < eff_cap);
  assign lru_rank = idx_t'(used_r - count_t'(1));
  assign accept   = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (idx_r == used_r && !cmp_vld_r) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (!out_vld_r || out_tready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready  = (state_r == S_IDLE);
    scan_issue = (state_r == S_SCAN) && (idx_r < used_r);
    upd_fire   = (state_r == S_UPDATE) && (!out_vld_r || out_tready);
    rd_idx     = idx_r[IDX_W-1:0];

    if (hit_r)     upd_idx = hit_idx_r;
    else if (fill) upd_idx = used_r[IDX_W-1:0];
    else           upd_idx = victim_r;

    slot_wr.en   = upd_fire && (put_r == ACT_PUT);
    slot_wr.idx  = upd_idx;
    slot_wr.key  = key_r;
    slot_wr.data = val_r;

    rank_cmd.en       = upd_fire && (hit_r || (put_r == ACT_PUT));
    rank_cmd.op       = (!hit_r && fill) ? RANK_FILL : RANK_TOUCH;
    rank_cmd.slot     = upd_idx;
    rank_cmd.old_rank = hit_r ? hit_rank_r : lru_rank;
    rank_cmd.used     = used_r;
  end

  // datapath next values
  always_comb begin
    put_nxt      = put_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    idx_nxt      = idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_rank_nxt = hit_rank_r;
    hit_data_nxt = hit_data_r;
    victim_nxt   = victim_r;
    used_nxt     = used_r;
    out_vld_nxt  = out_vld_r;
    found_nxt    = found_r;
    rdata_nxt    = rdata_r;
    cmp_vld_nxt  = scan_issue;
    cmp_idx_nxt  = idx_r[IDX_W-1:0];

    if (accept) begin
      put_nxt = in_action;
      key_nxt = in_key;
      val_nxt = in_value;
      idx_nxt = '0;
      hit_nxt = 1'b0;
    end

    if (scan_issue) idx_nxt = idx_r + count_t'(1);

    // shared compare stage: one slot per cycle
    if (cmp_vld_r) begin
      if (!hit_r && rd_key == key_r) begin
        hit_nxt      = 1'b1;
        hit_idx_nxt  = cmp_idx_r;
        hit_rank_nxt = rd_rank;
        hit_data_nxt = rd_data;
      end
      if (count_t'(rd_rank) == used_r - count_t'(1)) victim_nxt = cmp_idx_r;
    end

    if (out_vld_r && out_tready) out_vld_nxt = 1'b0;

    if (upd_fire) begin
      out_vld_nxt = 1'b1;
      found_nxt   = hit_r;
      if (put_r == ACT_PUT) rdata_nxt = '0;
      else if (hit_r)       rdata_nxt = hit_data_r;
      else                  rdata_nxt = '1;
      if (put_r == ACT_PUT && fill) used_nxt = used_r + count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
      used_r    <= '0;
      out_vld_r <= 1'b0;
      idx_r     <= '0;
      hit_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      used_r    <= used_nxt;
      out_vld_r <= out_vld_nxt;
      idx_r     <= idx_nxt;
      hit_r     <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    put_r      <= put_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_rank_r <= hit_rank_nxt;
    hit_data_r <= hit_data_nxt;
    victim_r   <= victim_nxt;
    found_r    <= found_nxt;
    rdata_r    <= rdata_nxt;
  end

  assign out_tvalid    = out_vld_r;
  assign out_found     = found_r;
  assign out_read_data = rdata_r;

  a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmp_vld_r)
    else $error("input ready while a compare is still pending");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= used_r))
    else $error("scan address ran past the used slots");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |-> (used_r == $past(used_r) + count_t'(1)))
    else $error("slot count moved by more than one");

  a_fill_only_put_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_fire && (hit_r || put_r == ACT_GET)) |=> (used_r == $past(used_r)))
    else $error("slot count changed on a hit or a get");

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with true LRU replacement.
// ----------------------------------------------------------------------------
// sequence: after the input transfer the block scans the filled slots in order,
//   then updates them and registers out_tvalid; in_tready stays low until idle
// throughput: a new item is taken only once the last one is done, as the
//   block runs the one-slot-a-cycle key compare over the filled slots and
//   waits in the update state while the previous output is not yet taken
// reset: synchronous active-low; cache empty, capacity 16, no clearing pass
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key [31:0], value [63:32]
  input  logic [0:0]  in_tuser,   // action [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data [31:0]
  output logic [0:0]  out_tuser,  // found [0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // capacity [4:0]
);

  cap_t      cap_r;
  cap_t      cap_nxt;
  count_t    eff_cap;
  idx_t      rd_idx;
  word_t     rd_key;
  word_t     rd_data;
  idx_t      rd_rank;
  slot_wr_t  slot_wr;
  rank_cmd_t rank_cmd;
  logic      out_found;
  word_t     out_read_data;

  assign cfg_ready = 1'b1;
  assign cap_nxt   = (cfg_valid && cfg_ready) ? cfg_data : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign eff_cap = eff_capacity(cap_r);

  lkv_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_action     (in_tuser[0]),
    .in_key        (in_tdata[31:0]),
    .in_value      (in_tdata[63:32]),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_found     (out_found),
    .out_read_data (out_read_data),
    .eff_cap       (eff_cap),
    .rd_idx        (rd_idx),
    .rd_key        (rd_key),
    .rd_data       (rd_data),
    .rd_rank       (rd_rank),
    .slot_wr       (slot_wr),
    .rank_cmd      (rank_cmd)
  );

  lkv_slot_mem u_slot_mem (
    .clk     (clk),
    .wr      (slot_wr),
    .rd_idx  (rd_idx),
    .rd_key  (rd_key),
    .rd_data (rd_data)
  );

  lkv_rank_table u_rank_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (rank_cmd),
    .rd_idx  (rd_idx),
    .rd_rank (rd_rank)
  );

  assign out_tdata    = out_read_data;
  assign out_tuser[0] = out_found;

endmodule
